// ===== rtl/core/isotp_receive_reassembler_macros.svh =====
// assertion macros for the isotp receive reassembler
`ifndef ISOTP_RECEIVE_REASSEMBLER_MACROS_SVH
`define ISOTP_RECEIVE_REASSEMBLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ISOTP_RX_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isotp_rx check failed");

// next-cycle implication, checked outside reset
`define ISOTP_RX_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isotp_rx check failed");

`endif

// ===== rtl/core/isotp_rx_pkg.sv =====
// shared types and constants of the isotp receive reassembler
package isotp_rx_pkg;

	localparam logic [1:0] OP_ARM   = 2'd0;
	localparam logic [1:0] OP_FRAME = 2'd1;
	localparam logic [1:0] OP_ABORT = 2'd2;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_FLOW  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_SINGLE = 3'd0;
	localparam logic [2:0] ERR_FIRST  = 3'd1;
	localparam logic [2:0] ERR_SEQ    = 3'd2;
	localparam logic [2:0] ERR_SHORT  = 3'd3;
	localparam logic [2:0] ERR_TYPE   = 3'd4;

	localparam logic [3:0] PCI_SINGLE = 4'h0;
	localparam logic [3:0] PCI_FIRST  = 4'h1;
	localparam logic [3:0] PCI_CONSEC = 4'h2;

	localparam logic [3:0] FRAME_BYTES = 4'd8;
	localparam logic [3:0] SF_MAX_LEN  = 4'd7;
	localparam logic [2:0] FF_BYTES    = 3'd6;
	localparam logic [2:0] CF_MAX      = 3'd7;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_FLOW,
		FIN_ERROR,
		FIN_STREAM
	} fin_t;

	typedef struct packed {
		fin_t            fin;
		logic [2:0]      code;
		logic [2:0]      count;
		logic [6:0][7:0] bytes;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WRITE,
		B_FINISH,
		B_READ,
		B_EMIT
	} back_state_t;

endpackage

// ===== rtl/core/isotp_rx_front.sv =====
// frame decoder and reassembly control state
`include "isotp_receive_reassembler_macros.svh"
module isotp_rx_front import isotp_rx_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [1:0]    op,
	input  logic [3:0]    dlc,
	input  logic [7:0]    byte_0,
	input  logic [7:0]    byte_1,
	input  logic [7:0]    byte_2,
	input  logic [7:0]    byte_3,
	input  logic [7:0]    byte_4,
	input  logic [7:0]    byte_5,
	input  logic [7:0]    byte_6,
	input  logic [7:0]    byte_7,
	output logic          push,
	output cmd_t          cmd,
	output logic [AW-1:0] cmd_base,
	output logic [CW-1:0] cmd_len
);

	localparam logic [12:0] MAX_TOTAL = 13'(MAX_MESSAGE_BYTES);

	logic          awaiting_q, awaiting_d;
	logic          in_multi_q, in_multi_d;
	logic [CW-1:0] stored_q, stored_d;
	logic [CW-1:0] expected_q, expected_d;
	logic [3:0]    next_seq_q, next_seq_d;

	logic [7:0][7:0] b;
	logic [3:0]      dlc_eff;
	logic [3:0]      dlc_m1;
	logic [3:0]      ftype;
	logic [3:0]      nib;
	logic [11:0]     total;
	logic [CW-1:0]   remaining;
	logic [2:0]      copy;
	logic [CW-1:0]   sum;

	assign b         = {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};
	assign dlc_eff   = (dlc > FRAME_BYTES) ? FRAME_BYTES : dlc;
	assign dlc_m1    = dlc_eff - 4'd1;
	assign ftype     = byte_0[7:4];
	assign nib       = byte_0[3:0];
	assign total     = {nib, byte_1};
	assign remaining = expected_q - stored_q;
	assign copy      = (remaining > CW'(CF_MAX)) ? CF_MAX : remaining[2:0];
	assign sum       = stored_q + CW'(copy);

	always_comb begin
		awaiting_d = awaiting_q;
		in_multi_d = in_multi_q;
		stored_d   = stored_q;
		expected_d = expected_q;
		next_seq_d = next_seq_q;
		push       = 1'b0;
		cmd        = '0;
		cmd_base   = '0;
		cmd_len    = '0;
		if (accept) begin
			case (op)
				OP_ARM: begin
					awaiting_d = 1'b1;
					in_multi_d = 1'b0;
					stored_d   = '0;
					expected_d = '0;
					next_seq_d = '0;
				end
				OP_ABORT: begin
					awaiting_d = 1'b0;
					in_multi_d = 1'b0;
					stored_d   = '0;
					expected_d = '0;
				end
				OP_FRAME: begin
					if (awaiting_q && dlc != 4'd0) begin
						push = 1'b1;
						if (ftype == PCI_SINGLE) begin
							if (nib == 4'd0 || nib > SF_MAX_LEN || nib > dlc_m1) begin
								cmd.fin  = FIN_ERROR;
								cmd.code = ERR_SINGLE;
							end else begin
								cmd.fin    = FIN_STREAM;
								cmd.count  = nib[2:0];
								cmd.bytes  = b[7:1];
								cmd_len    = CW'(nib);
								awaiting_d = 1'b0;
								in_multi_d = 1'b0;
								stored_d   = '0;
								expected_d = '0;
							end
						end else if (ftype == PCI_FIRST && dlc_eff == FRAME_BYTES) begin
							if (total <= 12'd7 || {1'b0, total} > MAX_TOTAL) begin
								cmd.fin  = FIN_ERROR;
								cmd.code = ERR_FIRST;
							end else begin
								cmd.fin    = FIN_FLOW;
								cmd.count  = FF_BYTES;
								cmd.bytes  = {8'h00, b[7:2]};
								expected_d = total[CW-1:0];
								stored_d   = CW'(FF_BYTES);
								next_seq_d = 4'd1;
								in_multi_d = 1'b1;
							end
						end else if (ftype == PCI_CONSEC && in_multi_q) begin
							if (nib != next_seq_q) begin
								cmd.fin    = FIN_ERROR;
								cmd.code   = ERR_SEQ;
								in_multi_d = 1'b0;
							end else if ({1'b0, copy} > dlc_m1) begin
								cmd.fin  = FIN_ERROR;
								cmd.code = ERR_SHORT;
							end else begin
								cmd.count  = copy;
								cmd.bytes  = b[7:1];
								cmd_base   = stored_q[AW-1:0];
								next_seq_d = next_seq_q + 4'd1;
								if (sum >= expected_q) begin
									cmd.fin    = FIN_STREAM;
									cmd_len    = expected_q;
									awaiting_d = 1'b0;
									in_multi_d = 1'b0;
									stored_d   = '0;
									expected_d = '0;
								end else begin
									cmd.fin  = FIN_NONE;
									stored_d = sum;
								end
							end
						end else begin
							cmd.fin  = FIN_ERROR;
							cmd.code = ERR_TYPE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			in_multi_q <= 1'b0;
			stored_q   <= '0;
			expected_q <= '0;
			next_seq_q <= '0;
		end else begin
			awaiting_q <= awaiting_d;
			in_multi_q <= in_multi_d;
			stored_q   <= stored_d;
			expected_q <= expected_d;
			next_seq_q <= next_seq_d;
		end
	end

	`ISOTP_RX_ASSERT_IMP(a_multi_needs_wait, in_multi_q, awaiting_q)
	`ISOTP_RX_ASSERT_IMP(a_count_below_total, in_multi_q, stored_q < expected_q)

endmodule

// ===== rtl/core/isotp_rx_queue.sv =====
// command queue between frame decoder and executor
module isotp_rx_queue import isotp_rx_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == NW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/isotp_rx_back.sv =====
// command executor with message store and output register
`include "isotp_receive_reassembler_macros.svh"
module isotp_rx_back import isotp_rx_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	output logic          pop,
	input  cmd_t          q_cmd,
	input  logic [AW-1:0] q_base,
	input  logic [CW-1:0] q_len,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    kind,
	output logic [7:0]    data_byte,
	output logic [5:0]    byte_index,
	output logic [6:0]    msg_length,
	output logic [2:0]    error_code,
	output logic          last
);

	localparam logic [AW:0] STORE_END = (AW + 1)'(MAX_MESSAGE_BYTES);

	back_state_t   state_q, state_d;
	cmd_t          cmd_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] len_q;
	logic [2:0]    cnt_q, cnt_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [7:0]    mem [MAX_MESSAGE_BYTES];
	logic [7:0]    rd_data_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic          out_free;
	logic          is_last;
	logic          out_load;
	logic [1:0]    load_kind;
	logic [7:0]    load_data;
	logic [5:0]    load_idx;
	logic [6:0]    load_len;
	logic [2:0]    load_code;
	logic          load_last;
	logic [AW+5:0] idx_ext;
	logic [CW+6:0] len_ext;

	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [7:0]    data_q;
	logic [5:0]    out_idx_q;
	logic [6:0]    out_len_q;
	logic [2:0]    code_q;
	logic          last_q;

	assign out_free = !out_valid_q || out_ready;
	assign waddr    = base_q + AW'(cnt_q);
	assign is_last  = (CW'(idx_q) + CW'(1)) == len_q;
	assign idx_ext  = {6'b0, idx_q};
	assign len_ext  = {7'b0, len_q};

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		pop       = 1'b0;
		we        = 1'b0;
		out_load  = 1'b0;
		load_kind = KIND_BYTE;
		load_data = '0;
		load_idx  = '0;
		load_len  = '0;
		load_code = '0;
		load_last = 1'b1;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					cnt_d   = '0;
					state_d = (q_cmd.count != 3'd0) ? B_WRITE : B_FINISH;
				end
			end
			B_WRITE: begin
				we = 1'b1;
				if (cnt_q == cmd_q.count - 3'd1) begin
					state_d = B_FINISH;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			B_FINISH: begin
				case (cmd_q.fin)
					FIN_NONE: begin
						state_d = B_IDLE;
					end
					FIN_FLOW: begin
						if (out_free) begin
							out_load  = 1'b1;
							load_kind = KIND_FLOW;
							state_d   = B_IDLE;
						end
					end
					FIN_ERROR: begin
						if (out_free) begin
							out_load  = 1'b1;
							load_kind = KIND_ERROR;
							load_code = cmd_q.code;
							state_d   = B_IDLE;
						end
					end
					FIN_STREAM: begin
						idx_d   = '0;
						state_d = B_READ;
					end
					default: begin
						state_d = B_IDLE;
					end
				endcase
			end
			B_READ: begin
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					load_kind = KIND_BYTE;
					load_data = rd_data_q;
					load_idx  = idx_ext[5:0];
					load_len  = len_ext[6:0];
					load_last = is_last;
					if (is_last) begin
						state_d = B_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = B_READ;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= q_cmd;
			base_q <= q_base;
			len_q  <= q_len;
		end
	end

	// message store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= cmd_q.bytes[cnt_q];
		end
		rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q    <= load_kind;
			data_q    <= load_data;
			out_idx_q <= load_idx;
			out_len_q <= load_len;
			code_q    <= load_code;
			last_q    <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign byte_index = out_idx_q;
	assign msg_length = out_len_q;
	assign error_code = code_q;
	assign last       = last_q;

	`ISOTP_RX_ASSERT_IMP(a_write_in_store, we, ({1'b0, base_q} + (AW + 1)'(cnt_q)) < STORE_END)
	`ISOTP_RX_ASSERT_IMP(a_stream_len_set, state_q == B_READ || state_q == B_EMIT, len_q != '0)

endmodule

// ===== rtl/core/isotp_receive_reassembler.sv =====
// top level of the isotp receive reassembler
// Takes classic CAN frames (plus arm and timeout-abort beats) and rebuilds one
// transport-layer message of up to MAX_MESSAGE_BYTES bytes. The front end decodes
// each frame combinationally and registers the new reassembly state on accept; a
// frame beat is accepted in any cycle in which the four-entry command queue has
// room. The back end drains the queue: it picks a command, writes its stored
// frame bytes one at a time (up to 7, one store write port), then loads a flow
// control or error beat, streams a completed message out byte by byte (each byte
// read through the registered store read, then emitted), or goes back to idle
// after a mid-message frame. Output beats sit in a register; a stalled consumer
// holds the back end, and the front end stalls once the command queue is full.
// The store is not cleared at reset; only written bytes are ever streamed.
module isotp_receive_reassembler import isotp_rx_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [3:0] dlc,
	input  logic [7:0] byte_0,
	input  logic [7:0] byte_1,
	input  logic [7:0] byte_2,
	input  logic [7:0] byte_3,
	input  logic [7:0] byte_4,
	input  logic [7:0] byte_5,
	input  logic [7:0] byte_6,
	input  logic [7:0] byte_7,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [5:0] byte_index,
	output logic [6:0] msg_length,
	output logic [2:0] error_code,
	output logic       last
);

	localparam int AW = $clog2(MAX_MESSAGE_BYTES);
	localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int QW = $bits(cmd_t) + AW + CW;

	logic          accept;
	logic          f_push;
	cmd_t          f_cmd;
	logic [AW-1:0] f_base;
	logic [CW-1:0] f_len;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_data;
	cmd_t          b_cmd;
	logic [AW-1:0] b_base;
	logic [CW-1:0] b_len;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign {b_cmd, b_base, b_len} = q_data;

	isotp_rx_front #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
		.AW(AW),
		.CW(CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (op),
		.dlc      (dlc),
		.byte_0   (byte_0),
		.byte_1   (byte_1),
		.byte_2   (byte_2),
		.byte_3   (byte_3),
		.byte_4   (byte_4),
		.byte_5   (byte_5),
		.byte_6   (byte_6),
		.byte_7   (byte_7),
		.push     (f_push),
		.cmd      (f_cmd),
		.cmd_base (f_base),
		.cmd_len  (f_len)
	);

	isotp_rx_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_cmd, f_base, f_len}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	isotp_rx_back #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
		.AW(AW),
		.CW(CW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.pop        (q_pop),
		.q_cmd      (b_cmd),
		.q_base     (b_base),
		.q_len      (b_len),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.msg_length (msg_length),
		.error_code (error_code),
		.last       (last)
	);

endmodule

// ===== verif/isotp_rx_checker.sv =====
// checker for the isotp receive reassembler: predicts result beats and compares them
`timescale 1ns / 1ps

module isotp_rx_checker import isotp_rx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] op,
	input  logic [3:0] dlc,
	input  logic [7:0] byte_0,
	input  logic [7:0] byte_1,
	input  logic [7:0] byte_2,
	input  logic [7:0] byte_3,
	input  logic [7:0] byte_4,
	input  logic [7:0] byte_5,
	input  logic [7:0] byte_6,
	input  logic [7:0] byte_7,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] kind,
	input  logic [7:0] data_byte,
	input  logic [5:0] byte_index,
	input  logic [6:0] msg_length,
	input  logic [2:0] error_code,
	input  logic       last,
	output int         fails,
	output int         pending,
	output int         checked
);

	localparam int STORE_DEPTH = 64;

	typedef logic [7:0][7:0] frame_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [5:0] idx;
		logic [6:0] len;
		logic [2:0] code;
		logic       last;
	} rx_result_t;

	rx_result_t due_out[$];
	rx_result_t head;

	logic [7:0] msg_mem [STORE_DEPTH];
	int         have_cnt;
	int         want_total;
	logic [3:0] seq_next;
	logic       multi_on;
	logic       waiting;

	function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
		input logic [5:0] i, input logic [6:0] l, input logic [2:0] c, input logic t);
		rx_result_t r;
		r.kind = k;
		r.data = d;
		r.idx  = i;
		r.len  = l;
		r.code = c;
		r.last = t;
		due_out.push_back(r);
	endfunction

	function automatic void push_error(input logic [2:0] c);
		push_result(KIND_ERROR, '0, '0, '0, c, 1'b1);
	endfunction

	function automatic void clear_reasm();
		waiting    = 1'b0;
		multi_on   = 1'b0;
		have_cnt   = 0;
		want_total = 0;
	endfunction

	function automatic void finish_message(input int len);
		int n;
		n = (len > STORE_DEPTH) ? STORE_DEPTH : len;
		for (int i = 0; i < n; i++)
			push_result(KIND_BYTE, msg_mem[i], 6'(i), 7'(n), '0, i == n - 1);
		clear_reasm();
	endfunction

	function automatic void reassemble(input logic [1:0] o, input logic [3:0] d,
		input frame_t b);
		int n;
		int len;
		int total;
		int remaining;
		int copy;
		int pos;
		if (o == OP_ARM) begin
			clear_reasm();
			waiting  = 1'b1;
			seq_next = '0;
		end else if (o == OP_ABORT) begin
			clear_reasm();
		end else if (o == OP_FRAME && waiting && d != 0) begin
			n = (d > FRAME_BYTES) ? FRAME_BYTES : d;
			case (b[0][7:4])
				PCI_SINGLE: begin
					len = b[0][3:0];
					if (len == 0 || len > SF_MAX_LEN || len > n - 1) begin
						push_error(ERR_SINGLE);
					end else begin
						for (int i = 0; i < len; i++)
							msg_mem[i] = b[i + 1];
						finish_message(len);
					end
				end
				PCI_FIRST: begin
					if (n == FRAME_BYTES) begin
						total = {b[0][3:0], b[1]};
						if (total <= SF_MAX_LEN || total > STORE_DEPTH) begin
							push_error(ERR_FIRST);
						end else begin
							want_total = total;
							for (int i = 0; i < FF_BYTES; i++)
								msg_mem[i] = b[i + 2];
							have_cnt = FF_BYTES;
							seq_next = 4'd1;
							multi_on = 1'b1;
							push_result(KIND_FLOW, '0, '0, '0, '0, 1'b1);
						end
					end else begin
						push_error(ERR_TYPE);
					end
				end
				PCI_CONSEC: begin
					if (!multi_on) begin
						push_error(ERR_TYPE);
					end else if (b[0][3:0] != seq_next) begin
						multi_on = 1'b0;
						push_error(ERR_SEQ);
					end else begin
						remaining = (want_total > have_cnt) ? want_total - have_cnt : 0;
						copy = (remaining > CF_MAX) ? CF_MAX : remaining;
						if (copy > n - 1) begin
							push_error(ERR_SHORT);
						end else begin
							for (int i = 0; i < copy; i++) begin
								pos = have_cnt + i;
								if (pos < STORE_DEPTH)
									msg_mem[pos] = b[i + 1];
							end
							have_cnt += copy;
							seq_next = seq_next + 4'd1;
							if (have_cnt >= want_total)
								finish_message(want_total);
						end
					end
				end
				default: push_error(ERR_TYPE);
			endcase
		end
	endfunction

	function automatic void check_field(input string name, input int e, input int a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_out.delete();
			for (int i = 0; i < STORE_DEPTH; i++)
				msg_mem[i] = '0;
			clear_reasm();
			seq_next = '0;
			fails    = 0;
			pending  = 0;
			checked  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_out.size() == 0) begin
					$error("result beat with nothing expected: kind %0d", kind);
					fails++;
				end else begin
					head = due_out.pop_front();
					check_field("kind", head.kind, kind);
					check_field("data_byte", head.data, data_byte);
					check_field("byte_index", head.idx, byte_index);
					check_field("msg_length", head.len, msg_length);
					check_field("error_code", head.code, error_code);
					check_field("last", head.last, last);
					checked++;
				end
			end
			if (in_valid && in_ready)
				reassemble(op, dlc, {byte_7, byte_6, byte_5, byte_4,
					byte_3, byte_2, byte_1, byte_0});
			pending = due_out.size();
		end
	end

endmodule

// ===== verif/tb_isotp_receive_reassembler.sv =====
// testbench top for the isotp receive reassembler: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_isotp_receive_reassembler;
	import isotp_rx_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_BEATS = 60;

	typedef logic [7:0][7:0] frame_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] op = OP_ARM;
	logic [3:0] dlc = '0;
	logic [7:0] byte_0 = '0;
	logic [7:0] byte_1 = '0;
	logic [7:0] byte_2 = '0;
	logic [7:0] byte_3 = '0;
	logic [7:0] byte_4 = '0;
	logic [7:0] byte_5 = '0;
	logic [7:0] byte_6 = '0;
	logic [7:0] byte_7 = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic [6:0] msg_length;
	logic [2:0] error_code;
	logic       last;

	int fails;
	int pending;
	int checked;
	int beats_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	isotp_receive_reassembler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .dlc(dlc),
		.byte_0(byte_0), .byte_1(byte_1), .byte_2(byte_2), .byte_3(byte_3),
		.byte_4(byte_4), .byte_5(byte_5), .byte_6(byte_6), .byte_7(byte_7),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .data_byte(data_byte),
		.byte_index(byte_index), .msg_length(msg_length), .error_code(error_code),
		.last(last)
	);

	isotp_rx_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .dlc(dlc),
		.byte_0(byte_0), .byte_1(byte_1), .byte_2(byte_2), .byte_3(byte_3),
		.byte_4(byte_4), .byte_5(byte_5), .byte_6(byte_6), .byte_7(byte_7),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .data_byte(data_byte),
		.byte_index(byte_index), .msg_length(msg_length), .error_code(error_code),
		.last(last), .fails(fails), .pending(pending), .checked(checked)
	);

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic frame_t rand_frame();
		frame_t f;
		for (int i = 0; i < 8; i++)
			f[i] = 8'($urandom);
		return f;
	endfunction

	// at least min_dlc, now and then above 8
	function automatic logic [3:0] frame_dlc(input int min_dlc);
		if ($urandom_range(7) == 0)
			return 4'($urandom_range(15, 9));
		return 4'($urandom_range(8, min_dlc));
	endfunction

	function automatic int msg_size();
		if ($urandom_range(7) == 0)
			return 64;
		return $urandom_range(40, 1);
	endfunction

	task automatic send_beat(input logic [1:0] o, input logic [3:0] d, input frame_t f);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		dlc      <= d;
		byte_0   <= f[0];
		byte_1   <= f[1];
		byte_2   <= f[2];
		byte_3   <= f[3];
		byte_4   <= f[4];
		byte_5   <= f[5];
		byte_6   <= f[6];
		byte_7   <= f[7];
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_message(input int total, input bit faulty);
		frame_t f;
		int sent;
		int copy;
		logic [3:0] seq;
		f = rand_frame();
		if (total <= SF_MAX_LEN) begin
			f[0] = {PCI_SINGLE, 4'(total)};
			send_beat(OP_FRAME, frame_dlc(total + 1), f);
			return;
		end
		f[0] = {PCI_FIRST, 4'(total >> 8)};
		f[1] = 8'(total);
		send_beat(OP_FRAME, frame_dlc(FRAME_BYTES), f);
		sent = FF_BYTES;
		seq = 4'd1;
		while (sent < total) begin
			copy = (total - sent > CF_MAX) ? CF_MAX : total - sent;
			f = rand_frame();
			f[0] = {PCI_CONSEC, seq};
			if (faulty && $urandom_range(11) == 0) begin
				case ($urandom_range(2))
					0: begin
						f[0][3:0] = seq + 4'($urandom_range(15, 1));
						send_beat(OP_FRAME, frame_dlc(copy + 1), f);
						return;
					end
					1: send_beat(OP_FRAME, 4'($urandom_range(copy, 1)), f);
					default: begin
						send_beat(OP_ABORT, 4'($urandom), rand_frame());
						return;
					end
				endcase
			end
			send_beat(OP_FRAME, frame_dlc(copy + 1), f);
			sent += copy;
			seq = seq + 4'd1;
		end
	endtask

	task automatic send_noise();
		frame_t f;
		f = rand_frame();
		case ($urandom_range(3))
			0: f[0][7:4] = PCI_SINGLE;
			1: f[0][7:4] = PCI_FIRST;
			2: f[0][7:4] = PCI_CONSEC;
			default: ;
		endcase
		send_beat(OP_FRAME, 4'($urandom_range(15)), f);
	endtask

	initial begin
		frame_t f;
		int stop_at;
		int pick;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: ignored beats, then each frame kind and error
		send_beat(OP_UNUSED, 4'($urandom), rand_frame());
		send_beat(OP_ABORT, 4'd0, '0);
		send_beat(OP_ARM, 4'hF, '1);
		f = rand_frame();
		f[0] = {PCI_SINGLE, 4'd2};
		send_beat(OP_FRAME, 4'd0, f);
		f = '1;
		f[0] = {PCI_SINGLE, SF_MAX_LEN};
		send_beat(OP_FRAME, 4'hF, f);
		send_beat(OP_ARM, 4'd0, '0);
		f = '0;
		f[0] = {PCI_SINGLE, 4'd1};
		send_beat(OP_FRAME, 4'd2, f);
		send_beat(OP_ARM, 4'd8, rand_frame());
		f = rand_frame();
		f[0] = {PCI_SINGLE, 4'd0};
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = {PCI_SINGLE, 4'hF};
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = {PCI_SINGLE, 4'd5};
		send_beat(OP_FRAME, 4'd3, f);
		f[0] = {PCI_FIRST, 4'h0};
		f[1] = 8'd7;
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = {PCI_FIRST, 4'hF};
		f[1] = 8'hFF;
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = {PCI_FIRST, 4'h0};
		f[1] = 8'd65;
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[1] = 8'd20;
		send_beat(OP_FRAME, 4'd7, f);
		f[0] = {PCI_CONSEC, 4'd1};
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = 8'h30;
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f = '1;
		f[0] = {PCI_FIRST, 4'h0};
		f[1] = 8'd8;
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = {PCI_CONSEC, 4'd1};
		send_beat(OP_FRAME, 4'd2, f);
		send_beat(OP_FRAME, 4'd3, f);
		send_beat(OP_ARM, 4'd0, rand_frame());
		f = rand_frame();
		f[0] = {PCI_FIRST, 4'h0};
		f[1] = 8'd20;
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = {PCI_CONSEC, 4'd5};
		send_beat(OP_FRAME, FRAME_BYTES, f);
		f[0] = {PCI_CONSEC, 4'd2};
		send_beat(OP_FRAME, FRAME_BYTES, f);
		send_beat(OP_ABORT, 4'hF, '1);
		f[0] = {PCI_SINGLE, 4'd1};
		send_beat(OP_FRAME, FRAME_BYTES, f);
		drain_results();

		// random: mostly armed, well-formed messages with some faults and noise
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 53 : 0;
			recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 12 : 0;
			stop_at = beats_sent + PHASE_BEATS;
			while (beats_sent < stop_at) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					send_beat(OP_ARM, 4'($urandom), rand_frame());
					send_message(msg_size(), 1'b1);
				end else if (pick < 82) begin
					send_message(msg_size(), 1'b1);
				end else if (pick < 94) begin
					send_noise();
				end else if (pick < 98) begin
					send_beat(OP_ABORT, 4'($urandom), rand_frame());
				end else begin
					send_beat(OP_UNUSED, 4'($urandom), rand_frame());
				end
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("summary: %0d beats driven under three flow-control mixes, %0d result beats compared",
			beats_sent, checked);
		$display("covered single and multi-frame messages up to 64 bytes, all error kinds, arm/abort");
		if (fails == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
